FILE: hw/rtl/pssh_pkg.sv
// ----------------------------------------------------------------------------
// pssh_pkg
// Shared types and constants for the protection-system header box parser.
// ----------------------------------------------------------------------------
package pssh_pkg;

	localparam int SYS_ID_BYTES = 16;
	localparam int KEY_ID_BYTES = 16;
	localparam int LEN_BYTES    = 4;
	localparam int TYPE_BYTES   = 4;
	localparam int FLAG_BYTES   = 3;

	localparam int SYS_ID_BITS = SYS_ID_BYTES * 8;
	localparam int CFG_W       = SYS_ID_BITS / 2;
	localparam int BIK_W       = $clog2(KEY_ID_BYTES);
	localparam int KEY_SHIFT   = $clog2(KEY_ID_BYTES);

	typedef logic [0:0] cfg_idx_t;
	localparam cfg_idx_t REG_SYS_ID_HIGH = 1'b0;
	localparam cfg_idx_t REG_SYS_ID_LOW  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_LEN     = 2'd1,
		ST_OTHER   = 2'd2,
		ST_INVALID = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [31:0] box_size;
		logic        last_byte;
	} in_item_t;

	typedef struct packed {
		logic       data_valid;
		logic       data_kind;
		logic [7:0] data_byte_out;
		logic       data_end;
		logic       done_res;
		status_t    status;
	} out_item_t;

endpackage

FILE: hw/rtl/pssh_box_parser_core.sv
// ----------------------------------------------------------------------------
// pssh_box_parser_core
// Byte-serial parser of a protection-system-specific header box: checks the
// length and system id, emits key id and payload bytes, reports a status.
// ----------------------------------------------------------------------------
// the result item of an accepted byte is registered and shows in the next cycle
// throughput: one byte per cycle while the output is not stalled, set by the single parse step per byte
// a byte is taken while a result waits, as long as the output is not stalled
// reset clears the parser state, the result register and both id registers
module pssh_box_parser_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       byte_valid,
	output logic                       byte_stall,
	input  pssh_pkg::in_item_t         byte_item,
	output logic                       res_valid,
	input  logic                       res_stall,
	output pssh_pkg::out_item_t        res_item,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  pssh_pkg::cfg_idx_t         cfg_index,
	input  logic [pssh_pkg::CFG_W-1:0] cfg_data
);
	import pssh_pkg::*;

	typedef enum logic [3:0] {
		PH_LEN, PH_TYPE, PH_VER, PH_FLAGS, PH_SYSID, PH_KCOUNT,
		PH_KEYS, PH_DSIZE, PH_PAYLOAD, PH_TAIL, PH_SKIP
	} phase_t;

	phase_t             phase_q, phase_d;
	logic [31:0]        off_q, off_d;
	logic [31:0]        accum_q, accum_d;
	logic               ver_nz_q, ver_nz_d;
	logic               id_eq_q, id_eq_d;
	logic [31:0]        keys_left_q, keys_left_d;
	logic [BIK_W-1:0]   bik_q, bik_d;
	logic [31:0]        pay_left_q, pay_left_d;
	status_t            rstat_q, rstat_d;
	logic [CFG_W-1:0]   sid_high_q, sid_low_q;
	logic               res_valid_q;
	out_item_t          res_item_q, res_d;

	logic               accept;
	logic [SYS_ID_BITS-1:0] sys_id;
	logic [7:0]         sid_bytes [SYS_ID_BYTES];
	logic [BIK_W:0]     bik_inc;
	logic [31:0]        shifted;
	logic [31:0]        rem;
	logic               keys_too_many;
	logic               pay_too_big;

	assign byte_stall = res_valid_q && res_stall;
	assign accept     = byte_valid && !byte_stall;
	assign cfg_ready  = 1'b1;
	assign res_valid  = res_valid_q;
	assign res_item   = res_item_q;

	assign sys_id = {sid_high_q, sid_low_q};
	always_comb begin
		for (int i = 0; i < SYS_ID_BYTES; i++) begin
			sid_bytes[i] = sys_id[(SYS_ID_BYTES-1-i)*8 +: 8];
		end
	end

	assign bik_inc = {1'b0, bik_q} + (BIK_W+1)'(1);
	assign shifted = {accum_q[23:0], byte_item.data_byte};
	assign rem     = (off_q < byte_item.box_size) ?
		(byte_item.box_size - off_q - 32'd1) : 32'd0;
	assign keys_too_many = {shifted, KEY_SHIFT'(0)} > {KEY_SHIFT'(0), rem};
	assign pay_too_big   = shifted > rem;

	always_comb begin
		phase_d     = phase_q;
		accum_d     = accum_q;
		ver_nz_d    = ver_nz_q;
		id_eq_d     = id_eq_q;
		keys_left_d = keys_left_q;
		bik_d       = bik_q;
		pay_left_d  = pay_left_q;
		rstat_d     = rstat_q;
		off_d       = (off_q != '1) ? off_q + 32'd1 : off_q;
		res_d       = '0;

		case (phase_q)
			PH_LEN: begin
				accum_d = shifted;
				if (bik_inc >= (BIK_W+1)'(LEN_BYTES)) begin
					bik_d = '0;
					if (shifted != byte_item.box_size) begin
						rstat_d = ST_LEN;
						phase_d = PH_SKIP;
					end else begin
						phase_d = PH_TYPE;
					end
				end else begin
					bik_d = bik_inc[BIK_W-1:0];
				end
			end
			PH_TYPE: begin
				accum_d = shifted;
				if (bik_inc >= (BIK_W+1)'(TYPE_BYTES)) begin
					bik_d   = '0;
					phase_d = PH_VER;
				end else begin
					bik_d = bik_inc[BIK_W-1:0];
				end
			end
			PH_VER: begin
				ver_nz_d = byte_item.data_byte != 8'd0;
				bik_d    = '0;
				phase_d  = PH_FLAGS;
			end
			PH_FLAGS: begin
				accum_d = shifted;
				if (bik_inc >= (BIK_W+1)'(FLAG_BYTES)) begin
					bik_d   = '0;
					phase_d = PH_SYSID;
				end else begin
					bik_d = bik_inc[BIK_W-1:0];
				end
			end
			PH_SYSID: begin
				accum_d = shifted;
				id_eq_d = id_eq_q && (sid_bytes[bik_q] == byte_item.data_byte);
				if (bik_inc >= (BIK_W+1)'(SYS_ID_BYTES)) begin
					bik_d = '0;
					if (!id_eq_d) begin
						rstat_d = ST_OTHER;
						phase_d = PH_SKIP;
					end else begin
						phase_d = ver_nz_q ? PH_KCOUNT : PH_DSIZE;
					end
				end else begin
					bik_d = bik_inc[BIK_W-1:0];
				end
			end
			PH_KCOUNT: begin
				accum_d = shifted;
				if (bik_inc >= (BIK_W+1)'(LEN_BYTES)) begin
					bik_d       = '0;
					keys_left_d = shifted;
					if (keys_too_many) begin
						rstat_d = ST_INVALID;
						phase_d = PH_SKIP;
					end else begin
						phase_d = (shifted == 32'd0) ? PH_DSIZE : PH_KEYS;
					end
				end else begin
					bik_d = bik_inc[BIK_W-1:0];
				end
			end
			PH_KEYS: begin
				res_d.data_valid    = 1'b1;
				res_d.data_kind     = 1'b0;
				res_d.data_byte_out = byte_item.data_byte;
				if (bik_inc >= (BIK_W+1)'(KEY_ID_BYTES)) begin
					res_d.data_end = 1'b1;
					bik_d          = '0;
					keys_left_d    = keys_left_q - 32'd1;
					if (keys_left_q == 32'd1) begin
						phase_d = PH_DSIZE;
					end
				end else begin
					bik_d = bik_inc[BIK_W-1:0];
				end
			end
			PH_DSIZE: begin
				accum_d = shifted;
				if (bik_inc >= (BIK_W+1)'(LEN_BYTES)) begin
					bik_d = '0;
					if (pay_too_big) begin
						rstat_d = ST_INVALID;
						phase_d = PH_SKIP;
					end else begin
						pay_left_d = shifted;
						phase_d    = (shifted == 32'd0) ? PH_TAIL : PH_PAYLOAD;
					end
				end else begin
					bik_d = bik_inc[BIK_W-1:0];
				end
			end
			PH_PAYLOAD: begin
				res_d.data_valid    = 1'b1;
				res_d.data_kind     = 1'b1;
				res_d.data_byte_out = byte_item.data_byte;
				if (pay_left_q <= 32'd1) begin
					res_d.data_end = 1'b1;
					pay_left_d     = '0;
					phase_d        = PH_TAIL;
				end else begin
					pay_left_d = pay_left_q - 32'd1;
				end
			end
			default: begin
			end
		endcase

		if (byte_item.last_byte) begin
			res_d.done_res = 1'b1;
			res_d.status   = (phase_d != PH_TAIL && phase_d != PH_SKIP) ?
				ST_INVALID : rstat_d;
			phase_d     = PH_LEN;
			off_d       = '0;
			accum_d     = '0;
			ver_nz_d    = 1'b0;
			id_eq_d     = 1'b1;
			keys_left_d = '0;
			bik_d       = '0;
			pay_left_d  = '0;
			rstat_d     = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LEN;
			off_q       <= '0;
			accum_q     <= '0;
			ver_nz_q    <= 1'b0;
			id_eq_q     <= 1'b1;
			keys_left_q <= '0;
			bik_q       <= '0;
			pay_left_q  <= '0;
			rstat_q     <= ST_OK;
			sid_high_q  <= '0;
			sid_low_q   <= '0;
			res_valid_q <= 1'b0;
			res_item_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SYS_ID_HIGH: sid_high_q <= cfg_data;
					REG_SYS_ID_LOW:  sid_low_q  <= cfg_data;
					default: begin
					end
				endcase
			end
			if (accept) begin
				phase_q     <= phase_d;
				off_q       <= off_d;
				accum_q     <= accum_d;
				ver_nz_q    <= ver_nz_d;
				id_eq_q     <= id_eq_d;
				keys_left_q <= keys_left_d;
				bik_q       <= bik_d;
				pay_left_q  <= pay_left_d;
				rstat_q     <= rstat_d;
				res_item_q  <= res_d;
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> res_valid)
		else $error("accepted byte produced no result item");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && byte_item.last_byte |=> phase_q == PH_LEN && off_q == 32'd0
			&& rstat_q == ST_OK)
		else $error("parser not cleared after last byte");

	a_status_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_item.done_res |-> res_item.status == ST_OK)
		else $error("status reported without done");

	a_end_needs_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.data_end |-> res_item.data_valid)
		else $error("data end without data byte");

endmodule

FILE: test/tb_pssh_box_parser_core.sv
// ----------------------------------------------------------------------------
// tb_pssh_box_parser_core
// Self-checking bench for the header box parser. Whole boxes are built byte
// by byte and streamed with random gaps and output stalls. A behavioral
// parser predicts every result item, which is compared field by field. A
// short table of boxes covers the corner cases, then random boxes follow,
// about half of them well formed, under several system id settings.
// ----------------------------------------------------------------------------
module tb_pssh_box_parser_core;
	import pssh_pkg::*;

	typedef enum logic [3:0] {
		PH_LEN, PH_TYPE, PH_VER, PH_FLAGS, PH_SYSID, PH_KCOUNT,
		PH_KEYS, PH_DSIZE, PH_PAYLOAD, PH_TAIL, PH_SKIP
	} parse_phase_t;

	typedef struct {
		logic [7:0]  ver;
		bit          id_ok;
		logic [31:0] kcount;
		int          ksent;
		logic [31:0] psize;
		int          psent;
		int          tail;
		bit          len_bad;
		bit          size_fix;
		logic [31:0] size_val;
		int          cut;
		int          noise;
		bit          typed;
		status_t     want;
	} box_desc_t;

	logic               clk;
	logic               arst_n;
	logic               byte_valid;
	logic               byte_stall;
	in_item_t           byte_item;
	logic               res_valid;
	logic               res_stall;
	out_item_t          res_item;
	logic               cfg_valid;
	logic               cfg_ready;
	cfg_idx_t           cfg_index;
	logic [CFG_W-1:0]   cfg_data;

	parse_phase_t p_ph;
	logic [31:0]  p_off;
	logic [31:0]  p_acc;
	logic [7:0]   p_ver;
	logic         p_ideq;
	logic [31:0]  p_keys;
	logic [3:0]   p_bik;
	logic [31:0]  p_pay;
	status_t      p_rst;
	logic [63:0]  id_hi;
	logic [63:0]  id_lo;

	out_item_t   out_items_q[$];
	logic [7:0]  box_q[$];
	logic [31:0] box_len;

	int  fails = 0;
	int  items_sent = 0;
	int  n_boxes = 0;
	int  n_cfg = 0;
	int  st_cnt[4] = '{0, 0, 0, 0};
	int  key_bytes = 0;
	int  pay_bytes = 0;
	int  stall_left = 0;
	bit  tx_quiet = 0;
	bit  rx_quiet = 0;

	box_desc_t directed [17] = '{
		'{8'd0,   1, 0,   0, 4,  4,  0, 0, 0, 0,             0,  0,  1, ST_OK},
		'{8'd1,   1, 2,   2, 3,  3,  0, 0, 0, 0,             0,  0,  1, ST_OK},
		'{8'd1,   1, 0,   0, 0,  0,  0, 0, 0, 0,             0,  0,  1, ST_OK},
		'{8'd0,   1, 0,   0, 2,  2,  0, 1, 0, 0,             0,  0,  1, ST_LEN},
		'{8'd0,   0, 0,   0, 2,  2,  0, 0, 0, 0,             0,  0,  1, ST_OTHER},
		'{8'd1,   0, 1,   1, 2,  2,  0, 0, 0, 0,             0,  0,  1, ST_OTHER},
		// too many key ids for the box
		'{8'd1,   1, 100, 1, 2,  2,  0, 0, 0, 0,             0,  0,  1, ST_INVALID},
		// payload size beyond the box
		'{8'd0,   1, 0,   0, 50, 5,  0, 0, 0, 0,             0,  0,  1, ST_INVALID},
		// box ends inside the payload
		'{8'd0,   1, 0,   0, 5,  5,  0, 0, 0, 0,             34, 0,  1, ST_INVALID},
		// trailing bytes after the payload
		'{8'd0,   1, 0,   0, 0,  0,  5, 0, 0, 0,             0,  0,  1, ST_OK},
		// bytes past box_size
		'{8'd0,   1, 0,   0, 0,  0,  6, 0, 1, 32,            0,  0,  1, ST_OK},
		'{8'd255, 1, 1,   1, 1,  1,  0, 0, 0, 0,             0,  0,  0, ST_OK},
		'{8'd0,   1, 0,   0, 8,  20, 0, 0, 1, 32'hFFFF_FFFF, 36, 0,  1, ST_INVALID},
		'{8'd0,   1, 0,   0, 0,  0,  0, 0, 1, 0,             1,  0,  1, ST_INVALID},
		'{8'd0,   1, 0,   0, 0,  0,  0, 0, 1, 0,             8,  0,  1, ST_INVALID},
		// ends inside the length field
		'{8'd0,   1, 0,   0, 0,  0,  0, 1, 0, 0,             3,  0,  1, ST_INVALID},
		'{8'd0,   1, 0,   0, 0,  0,  0, 0, 0, 0,             0,  20, 0, ST_OK}
	};

	pssh_box_parser_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_item   (res_item),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic void clear_parse();
		p_ph   = PH_LEN;
		p_off  = '0;
		p_acc  = '0;
		p_ver  = '0;
		p_ideq = 1'b1;
		p_keys = '0;
		p_bik  = '0;
		p_pay  = '0;
		p_rst  = ST_OK;
	endfunction

	function automatic bit take_field(int n, logic [7:0] b);
		p_acc = {p_acc[23:0], b};
		if (int'(p_bik) + 1 >= n) begin
			p_bik = '0;
			return 1'b1;
		end
		p_bik = p_bik + 4'd1;
		return 1'b0;
	endfunction

	function automatic logic [7:0] id_byte(logic [3:0] i);
		logic [63:0] w;
		w = i[3] ? id_lo : id_hi;
		return w[8 * (7 - i[2:0]) +: 8];
	endfunction

	function automatic void skip_as(status_t s);
		p_rst = s;
		p_ph  = PH_SKIP;
	endfunction

	function automatic out_item_t parse_byte(in_item_t it);
		out_item_t       r;
		longint unsigned rem;
		r = '0;
		rem = (p_off < it.box_size) ? 64'(it.box_size - p_off - 32'd1) : 64'd0;
		case (p_ph)
			PH_LEN: begin
				if (take_field(LEN_BYTES, it.data_byte)) begin
					if (p_acc != it.box_size)
						skip_as(ST_LEN);
					else
						p_ph = PH_TYPE;
				end
			end
			PH_TYPE: begin
				if (take_field(TYPE_BYTES, it.data_byte))
					p_ph = PH_VER;
			end
			PH_VER: begin
				p_ver = it.data_byte;
				p_bik = '0;
				p_ph  = PH_FLAGS;
			end
			PH_FLAGS: begin
				if (take_field(FLAG_BYTES, it.data_byte))
					p_ph = PH_SYSID;
			end
			PH_SYSID: begin
				if (id_byte(p_bik) != it.data_byte)
					p_ideq = 1'b0;
				if (take_field(SYS_ID_BYTES, it.data_byte)) begin
					if (!p_ideq)
						skip_as(ST_OTHER);
					else if (p_ver > 0)
						p_ph = PH_KCOUNT;
					else
						p_ph = PH_DSIZE;
				end
			end
			PH_KCOUNT: begin
				if (take_field(LEN_BYTES, it.data_byte)) begin
					p_keys = p_acc;
					if ((64'(p_keys) << 4) > rem)
						skip_as(ST_INVALID);
					else if (p_keys == 0)
						p_ph = PH_DSIZE;
					else
						p_ph = PH_KEYS;
				end
			end
			PH_KEYS: begin
				r.data_valid    = 1'b1;
				r.data_byte_out = it.data_byte;
				if (p_bik == 4'd15) begin
					r.data_end = 1'b1;
					p_bik  = '0;
					p_keys = p_keys - 32'd1;
					if (p_keys == 0)
						p_ph = PH_DSIZE;
				end else begin
					p_bik = p_bik + 4'd1;
				end
			end
			PH_DSIZE: begin
				if (take_field(LEN_BYTES, it.data_byte)) begin
					if (64'(p_acc) > rem) begin
						skip_as(ST_INVALID);
					end else begin
						p_pay = p_acc;
						if (p_pay == 0)
							p_ph = PH_TAIL;
						else
							p_ph = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				r.data_valid    = 1'b1;
				r.data_kind     = 1'b1;
				r.data_byte_out = it.data_byte;
				if (p_pay <= 1) begin
					r.data_end = 1'b1;
					p_pay = '0;
					p_ph  = PH_TAIL;
				end else begin
					p_pay = p_pay - 32'd1;
				end
			end
			default: begin
			end
		endcase
		if (p_off != 32'hFFFF_FFFF)
			p_off = p_off + 32'd1;
		if (it.last_byte) begin
			if (p_ph != PH_TAIL && p_ph != PH_SKIP)
				p_rst = ST_INVALID;
			r.done_res = 1'b1;
			r.status   = p_rst;
			clear_parse();
		end
		return r;
	endfunction

	function automatic void build_box(box_desc_t d);
		int          natural;
		logic [31:0] lenf;
		int          flip;
		box_q.delete();
		if (d.noise > 0) begin
			repeat (d.noise) box_q.push_back(8'($urandom));
			box_len = $urandom;
			return;
		end
		repeat (4) box_q.push_back(8'h00);
		box_q.push_back(8'h70);
		box_q.push_back(8'h73);
		box_q.push_back(8'h73);
		box_q.push_back(8'h68);
		box_q.push_back(d.ver);
		repeat (3) box_q.push_back(8'($urandom));
		for (int i = 0; i < SYS_ID_BYTES; i++)
			box_q.push_back(id_byte(4'(i)));
		if (!d.id_ok) begin
			flip = $urandom_range(12, 27);
			box_q[flip] = box_q[flip] ^ 8'($urandom_range(1, 255));
		end
		if (d.ver != 0) begin
			for (int k = 3; k >= 0; k--)
				box_q.push_back(d.kcount[8 * k +: 8]);
			repeat (d.ksent * KEY_ID_BYTES) box_q.push_back(8'($urandom));
		end
		for (int k = 3; k >= 0; k--)
			box_q.push_back(d.psize[8 * k +: 8]);
		repeat (d.psent) box_q.push_back(8'($urandom));
		repeat (d.tail) box_q.push_back(8'($urandom));
		natural = box_q.size();
		box_len = d.size_fix ? d.size_val : 32'(natural);
		lenf = d.len_bad ? (box_len ^ (32'($urandom) | 32'd1)) : box_len;
		for (int k = 0; k < 4; k++)
			box_q[k] = lenf[8 * (3 - k) +: 8];
		if (d.cut > 0)
			while (box_q.size() > d.cut) void'(box_q.pop_back());
	endfunction

	function automatic box_desc_t random_box();
		box_desc_t d;
		int        pick;
		pick       = $urandom_range(0, 99);
		d.ver      = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
		d.id_ok    = 1;
		d.kcount   = $urandom_range(0, 3);
		d.ksent    = int'(d.kcount);
		d.psize    = $urandom_range(0, 40);
		d.psent    = int'(d.psize);
		d.tail     = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0;
		d.len_bad  = 0;
		d.size_fix = 0;
		d.size_val = '0;
		d.cut      = 0;
		d.noise    = 0;
		d.typed    = 0;
		d.want     = ST_OK;
		if (pick < 8) begin
			d.len_bad = 1;
		end else if (pick < 16) begin
			d.id_ok = 0;
		end else if (pick < 24) begin
			d.cut = $urandom_range(1, 60);
		end else if (pick < 30) begin
			d.ver    = 8'($urandom_range(1, 255));
			d.kcount = $urandom;
			d.ksent  = $urandom_range(0, 2);
		end else if (pick < 36) begin
			d.psent = $urandom_range(0, 20);
			d.psize = (pick < 33) ? 32'($urandom) : 32'(d.psent + $urandom_range(1, 20));
		end else if (pick < 42) begin
			d.size_fix = 1;
			d.size_val = $urandom;
			d.cut      = $urandom_range(1, 80);
		end else if (pick < 46) begin
			d.size_fix = 1;
			d.size_val = $urandom_range(12, 70);
		end else if (pick < 50) begin
			d.noise = $urandom_range(1, 40);
		end
		return d;
	endfunction

	task automatic send_box(box_desc_t d);
		in_item_t  it;
		out_item_t r;
		int        gap;
		build_box(d);
		n_boxes++;
		tx_quiet = ($urandom_range(0, 3) == 0);
		rx_quiet = ($urandom_range(0, 3) == 0);
		foreach (box_q[i]) begin
			it.data_byte = box_q[i];
			it.box_size  = box_len;
			it.last_byte = (i == box_q.size() - 1);
			gap = tx_quiet ? 0 : $urandom_range(0, 10);
			repeat (gap) begin
				@(negedge clk);
				byte_valid <= 1'b0;
			end
			@(negedge clk);
			byte_valid <= 1'b1;
			byte_item  <= it;
			do @(posedge clk); while (!(byte_valid && !byte_stall));
			r = parse_byte(it);
			if (it.last_byte && d.typed)
				r.status = d.want;
			out_items_q.push_back(r);
			items_sent++;
		end
	endtask

	task automatic drain();
		int waited;
		waited = 0;
		@(negedge clk);
		byte_valid <= 1'b0;
		while (out_items_q.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		if (out_items_q.size() != 0) begin
			$error("%0d result items never arrived", out_items_q.size());
			fails++;
			out_items_q.delete();
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [63:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_SYS_ID_HIGH)
			id_hi = val;
		else
			id_lo = val;
		n_cfg++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_id(logic [63:0] hi, logic [63:0] lo);
		write_reg(REG_SYS_ID_HIGH, hi);
		write_reg(REG_SYS_ID_LOW, lo);
	endtask

	// output side stall generator
	initial begin
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				res_stall <= 1'b1;
				stall_left--;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n && res_valid && !res_stall) begin
			stall_left = rx_quiet ? 0 : $urandom_range(0, 10);
			if (out_items_q.size() == 0) begin
				$error("result item with nothing expected");
				fails++;
			end else begin
				want = out_items_q.pop_front();
				if (res_item.data_valid !== want.data_valid) begin
					$error("data_valid: expected %0d, got %0d",
						want.data_valid, res_item.data_valid);
					fails++;
				end
				if (res_item.data_kind !== want.data_kind) begin
					$error("data_kind: expected %0d, got %0d",
						want.data_kind, res_item.data_kind);
					fails++;
				end
				if (res_item.data_byte_out !== want.data_byte_out) begin
					$error("data_byte_out: expected %0h, got %0h",
						want.data_byte_out, res_item.data_byte_out);
					fails++;
				end
				if (res_item.data_end !== want.data_end) begin
					$error("data_end: expected %0d, got %0d",
						want.data_end, res_item.data_end);
					fails++;
				end
				if (res_item.done_res !== want.done_res) begin
					$error("done_res: expected %0d, got %0d",
						want.done_res, res_item.done_res);
					fails++;
				end
				if (res_item.status !== want.status) begin
					$error("status: expected %0d, got %0d",
						want.status, res_item.status);
					fails++;
				end
				if (want.done_res)
					st_cnt[want.status]++;
				if (want.data_valid) begin
					if (want.data_kind)
						pay_bytes++;
					else
						key_bytes++;
				end
			end
		end
	end

	initial begin : run
		int pass_no;
		int phase_end;
		byte_valid = 1'b0;
		byte_item  = '0;
		cfg_valid  = 1'b0;
		cfg_index  = REG_SYS_ID_HIGH;
		cfg_data   = '0;
		arst_n     = 1'b0;
		id_hi      = '0;
		id_lo      = '0;
		clear_parse();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_id(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
		foreach (directed[i])
			send_box(directed[i]);
		drain();

		for (pass_no = 0; pass_no < 4; pass_no++) begin
			case (pass_no)
				0: set_id(64'd0, 64'd0);
				1: set_id({64{1'b1}}, {64{1'b1}});
				default: set_id({$urandom, $urandom}, {$urandom, $urandom});
			endcase
			phase_end = items_sent + 250;
			while (items_sent < phase_end) begin
				send_box(random_box());
				// sender holds off until the parser has caught up
				if ($urandom_range(0, 9) == 0)
					drain();
			end
			drain();
		end

		$display("covered %0d boxes, %0d bytes, %0d id writes, %0d key id bytes, %0d payload bytes",
			n_boxes, items_sent, n_cfg, key_bytes, pay_bytes);
		$display("box status ok/len/other/invalid %0d/%0d/%0d/%0d",
			st_cnt[0], st_cnt[1], st_cnt[2], st_cnt[3]);
		if (fails == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : watchdog
		#20_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/pssh_pkg.sv
hw/rtl/pssh_box_parser_core.sv
test/tb_pssh_box_parser_core.sv
